FILE: sv/custom_isa_execute_unit_core_defines.svh
// assertion macros shared by the execute unit rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef CUSTOM_ISA_EXECUTE_UNIT_CORE_DEFINES_SVH
`define CUSTOM_ISA_EXECUTE_UNIT_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CISEU_ASSERT_IMM(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define CISEU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ciseu_pkg.sv
// shared types and constants for the execute unit
// no dependencies
package ciseu_pkg;

    // data store depth, a power of two; register count excludes r0
    localparam int unsigned DATA_WORDS  = 1024;
    localparam int unsigned REG_COUNT   = 31;
    localparam int unsigned DATA_AW     = $clog2(DATA_WORDS);
    localparam int unsigned RF_AW       = $clog2(REG_COUNT);

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned OPC_W       = 4;
    localparam int unsigned REG_IDX_W   = 5;
    localparam int unsigned IMM_W       = 18;
    localparam int unsigned JADDR_W     = 28;
    localparam int unsigned SHAMT_W     = 13;
    localparam int unsigned SHIFT_W     = 5;
    localparam int unsigned MEM_ADDR_W  = 10;

    // instruction field positions
    localparam int unsigned OPC_LSB     = 28;
    localparam int unsigned RA_LSB      = 23;
    localparam int unsigned RB_LSB      = 18;
    localparam int unsigned RC_LSB      = 13;

    // decoded item queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_MOVI  = 4'd3,
        OP_JEQ   = 4'd4,
        OP_AND   = 4'd5,
        OP_XORI  = 4'd6,
        OP_JMP   = 4'd7,
        OP_LSL   = 4'd8,
        OP_LSR   = 4'd9,
        OP_LOAD  = 4'd10,
        OP_STORE = 4'd11
    } opcode_t;

    // item after decode
    typedef struct packed {
        opcode_t                op;
        logic                   bad;
        logic [REG_IDX_W-1:0]   ra;
        logic [REG_IDX_W-1:0]   rb;
        logic [REG_IDX_W-1:0]   rc;
        logic                   ra_ok;
        logic                   rb_ok;
        logic                   rc_ok;
        logic [IMM_W-1:0]       imm;
        logic [JADDR_W-1:0]     jaddr;
        logic [SHIFT_W-1:0]     shift;
        logic                   shift_big;
    } dec_t;

    // executed item held in the output stage
    typedef struct packed {
        logic [WORD_W-1:0]      next_pc;
        logic                   taken;
        logic                   wb_en;
        logic [REG_IDX_W-1:0]   wb_reg;
        logic [WORD_W-1:0]      alu;
        logic                   is_load;
        logic                   mem_write;
        logic [MEM_ADDR_W-1:0]  mem_addr;
        logic [WORD_W-1:0]      mem_data;
        logic                   bad;
    } wres_t;

endpackage

FILE: sv/ciseu_instr_if.sv
// instruction channel: valid/ready plus one instruction word
// depends on ciseu_pkg
interface ciseu_instr_if;
    logic                           valid;
    logic                           ready;
    logic [ciseu_pkg::WORD_W-1:0]   instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

FILE: sv/ciseu_result_if.sv
// result channel: valid/ready plus one executed item
// depends on ciseu_pkg
interface ciseu_result_if;
    logic                               valid;
    logic                               ready;
    logic [ciseu_pkg::WORD_W-1:0]       next_pc;
    logic                               branch_taken;
    logic                               wb_valid;
    logic [ciseu_pkg::REG_IDX_W-1:0]    wb_reg;
    logic signed [ciseu_pkg::WORD_W-1:0] wb_value;
    logic                               mem_write;
    logic [ciseu_pkg::MEM_ADDR_W-1:0]   mem_addr;
    logic signed [ciseu_pkg::WORD_W-1:0] mem_data;
    logic                               bad_opcode;

    modport source (output valid, output next_pc, output branch_taken, output wb_valid,
                    output wb_reg, output wb_value, output mem_write, output mem_addr,
                    output mem_data, output bad_opcode, input ready);
    modport sink   (input valid, input next_pc, input branch_taken, input wb_valid,
                    input wb_reg, input wb_value, input mem_write, input mem_addr,
                    input mem_data, input bad_opcode, output ready);
endinterface

FILE: sv/ciseu_front.sv
// front end: splits an instruction word into fields and classifies it
// depends on ciseu_pkg
module ciseu_front (
    input  logic [ciseu_pkg::WORD_W-1:0] instr_word,
    output ciseu_pkg::dec_t              dec
);
    import ciseu_pkg::*;

    logic [OPC_W-1:0]     opc;
    logic [SHAMT_W-1:0]   shamt;

    // register index is live when nonzero and within the file
    function automatic logic idx_ok(input logic [REG_IDX_W-1:0] idx);
        return (idx != '0) && (32'(idx) <= REG_COUNT);
    endfunction

    assign opc   = instr_word[OPC_LSB +: OPC_W];
    assign shamt = instr_word[SHAMT_W-1:0];

    always_comb
    begin
        dec.op        = opcode_t'(opc);
        // top four codes are unused
        dec.bad       = (opc > OP_STORE);
        dec.ra        = instr_word[RA_LSB +: REG_IDX_W];
        dec.rb        = instr_word[RB_LSB +: REG_IDX_W];
        dec.rc        = instr_word[RC_LSB +: REG_IDX_W];
        dec.ra_ok     = idx_ok(dec.ra);
        dec.rb_ok     = idx_ok(dec.rb);
        dec.rc_ok     = idx_ok(dec.rc);
        dec.imm       = instr_word[IMM_W-1:0];
        dec.jaddr     = instr_word[JADDR_W-1:0];
        dec.shift     = shamt[SHIFT_W-1:0];
        // any shift of 32 or more clears the word
        dec.shift_big = |shamt[SHAMT_W-1:SHIFT_W];
    end

endmodule

FILE: sv/ciseu_queue.sv
// short fifo of decoded items between front and back
// depends on ciseu_pkg
module ciseu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ciseu_pkg::dec_t push_item,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output ciseu_pkg::dec_t head_item
);
    import ciseu_pkg::*;

    dec_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (32'(cnt_reg) != QUEUE_DEPTH);
    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/ciseu_back.sv
// back end: register file, execute stage, data store and output stage
// depends on ciseu_pkg, ciseu_result_if and the assertion macro header
`include "custom_isa_execute_unit_core_defines.svh"

module ciseu_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  ciseu_pkg::dec_t         q_item,
    output logic                    q_pop,
    output logic                    init_done,
    ciseu_result_if.source          result
);
    import ciseu_pkg::*;

    // execute stage
    logic                   x_valid_reg;
    dec_t                   x_reg;
    logic [WORD_W-1:0]      rd_a_reg, rd_b_reg, rd_c_reg;
    logic                   vb_a_reg, vb_b_reg, vb_c_reg;
    logic [WORD_W-1:0]      pc_reg;

    // output stage
    logic                   w_valid_reg;
    wres_t                  w_reg;
    logic [WORD_W-1:0]      ld_data_reg;

    // most recent register write, for the read that overlapped it
    logic                   lw_valid_reg;
    logic [REG_IDX_W-1:0]   lw_idx_reg;
    logic [WORD_W-1:0]      lw_val_reg;

    // register file, two copies for three read ports
    logic [WORD_W-1:0]      rf_main [REG_COUNT];
    logic [WORD_W-1:0]      rf_aux  [REG_COUNT];
    logic [REG_COUNT-1:0]   rf_vld_reg;

    logic [WORD_W-1:0]      dmem [DATA_WORDS];
    logic [DATA_AW:0]       clr_cnt_reg;

    logic                   adv;
    logic                   rf_we;
    logic [RF_AW-1:0]       rf_widx;
    logic [WORD_W-1:0]      w_value;
    logic [WORD_W-1:0]      a_op, b_op, c_op;
    logic [WORD_W-1:0]      imm_ext;
    logic [WORD_W-1:0]      x_sum;
    logic [DATA_AW-1:0]     x_addr;
    logic                   x_wr;
    wres_t                  w_next;
    logic                   dm_we;
    logic [DATA_AW-1:0]     dm_waddr;
    logic [WORD_W-1:0]      dm_wdata;

    function automatic logic [RF_AW-1:0] rf_index(input logic [REG_IDX_W-1:0] idx,
                                                  input logic ok);
        return ok ? RF_AW'(idx - 1'b1) : '0;
    endfunction

    // newest value of a register: output stage, then last write, then the file
    function automatic logic [WORD_W-1:0] pick_operand(
        input logic [REG_IDX_W-1:0] idx,
        input logic                 ok,
        input logic [WORD_W-1:0]    rdata,
        input logic                 rvld,
        input logic                 wv,
        input wres_t                wr,
        input logic [WORD_W-1:0]    wval,
        input logic                 lv,
        input logic [REG_IDX_W-1:0] lidx,
        input logic [WORD_W-1:0]    lval
    );
        logic [WORD_W-1:0] v;
        v = '0;
        if (!ok)
        begin
            v = '0;
        end
        else if (wv && wr.wb_en && (wr.wb_reg == idx))
        begin
            v = wval;
        end
        else if (lv && (lidx == idx))
        begin
            v = lval;
        end
        else if (rvld)
        begin
            v = rdata;
        end
        return v;
    endfunction

    assign init_done = clr_cnt_reg[DATA_AW];
    assign adv       = !w_valid_reg || result.ready;
    assign q_pop     = adv && q_valid && init_done;
    assign w_value   = w_reg.is_load ? ld_data_reg : w_reg.alu;
    assign rf_we     = adv && w_valid_reg && w_reg.wb_en;
    assign rf_widx   = rf_index(w_reg.wb_reg, 1'b1);

    always_comb
    begin
        a_op = pick_operand(x_reg.ra, x_reg.ra_ok, rd_a_reg, vb_a_reg, w_valid_reg, w_reg,
                            w_value, lw_valid_reg, lw_idx_reg, lw_val_reg);
        b_op = pick_operand(x_reg.rb, x_reg.rb_ok, rd_b_reg, vb_b_reg, w_valid_reg, w_reg,
                            w_value, lw_valid_reg, lw_idx_reg, lw_val_reg);
        c_op = pick_operand(x_reg.rc, x_reg.rc_ok, rd_c_reg, vb_c_reg, w_valid_reg, w_reg,
                            w_value, lw_valid_reg, lw_idx_reg, lw_val_reg);
    end

    assign imm_ext = {{(WORD_W - IMM_W){1'b0}}, x_reg.imm};
    assign x_sum   = b_op + imm_ext;
    assign x_addr  = x_sum[DATA_AW-1:0];

    // execute
    always_comb
    begin
        x_wr             = 1'b0;
        w_next           = '0;
        w_next.next_pc   = pc_reg + 1'b1;
        case (x_reg.op)
            OP_ADD:
            begin
                w_next.alu = b_op + c_op;
                x_wr       = 1'b1;
            end
            OP_SUB:
            begin
                w_next.alu = b_op - c_op;
                x_wr       = 1'b1;
            end
            OP_MUL:
            begin
                w_next.alu = WORD_W'(b_op * c_op);
                x_wr       = 1'b1;
            end
            OP_MOVI:
            begin
                w_next.alu = imm_ext;
                x_wr       = 1'b1;
            end
            OP_JEQ:
            begin
                if (a_op == b_op)
                begin
                    w_next.next_pc = pc_reg + 1'b1 + imm_ext;
                    w_next.taken   = 1'b1;
                end
            end
            OP_AND:
            begin
                w_next.alu = b_op & c_op;
                x_wr       = 1'b1;
            end
            OP_XORI:
            begin
                w_next.alu = b_op ^ imm_ext;
                x_wr       = 1'b1;
            end
            OP_JMP:
            begin
                w_next.next_pc = {{(WORD_W - JADDR_W){1'b0}}, x_reg.jaddr};
                w_next.taken   = 1'b1;
            end
            OP_LSL:
            begin
                w_next.alu = x_reg.shift_big ? '0 : (b_op << x_reg.shift);
                x_wr       = 1'b1;
            end
            OP_LSR:
            begin
                w_next.alu = x_reg.shift_big ? '0 : (b_op >> x_reg.shift);
                x_wr       = 1'b1;
            end
            OP_LOAD:
            begin
                w_next.is_load  = 1'b1;
                w_next.mem_addr = MEM_ADDR_W'(x_addr);
                x_wr            = 1'b1;
            end
            OP_STORE:
            begin
                w_next.mem_write = 1'b1;
                w_next.mem_addr  = MEM_ADDR_W'(x_addr);
                w_next.mem_data  = a_op;
            end
            default:
            begin
                w_next.bad = 1'b1;
            end
        endcase
        // writes to r0 or beyond the file are dropped
        w_next.wb_en  = x_wr && x_reg.ra_ok;
        w_next.wb_reg = w_next.wb_en ? x_reg.ra : '0;
        if (!w_next.wb_en)
        begin
            w_next.alu = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            pc_reg       <= '0;
            lw_valid_reg <= 1'b0;
            rf_vld_reg   <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                x_valid_reg <= q_pop;
                w_valid_reg <= x_valid_reg;
                if (x_valid_reg)
                begin
                    pc_reg <= w_next.next_pc;
                end
            end
            if (rf_we)
            begin
                lw_valid_reg        <= 1'b1;
                rf_vld_reg[rf_widx] <= 1'b1;
            end
            if (!init_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            x_reg    <= q_item;
            vb_a_reg <= rf_vld_reg[rf_index(q_item.ra, q_item.ra_ok)];
            vb_b_reg <= rf_vld_reg[rf_index(q_item.rb, q_item.rb_ok)];
            vb_c_reg <= rf_vld_reg[rf_index(q_item.rc, q_item.rc_ok)];
        end
        if (adv && x_valid_reg)
        begin
            w_reg <= w_next;
        end
        if (rf_we)
        begin
            lw_idx_reg <= w_reg.wb_reg;
            lw_val_reg <= w_value;
        end
    end

    // register file ports
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_main[rf_widx] <= w_value;
            rf_aux[rf_widx]  <= w_value;
        end
        if (q_pop)
        begin
            rd_b_reg <= rf_main[rf_index(q_item.rb, q_item.rb_ok)];
            rd_c_reg <= rf_main[rf_index(q_item.rc, q_item.rc_ok)];
            rd_a_reg <= rf_aux[rf_index(q_item.ra, q_item.ra_ok)];
        end
    end

    // data store: clearing sweep or store on the write port, load on the read port
    assign dm_we    = !init_done || (adv && x_valid_reg && (x_reg.op == OP_STORE));
    assign dm_waddr = init_done ? x_addr : clr_cnt_reg[DATA_AW-1:0];
    assign dm_wdata = init_done ? a_op : '0;

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if (adv && x_valid_reg && (x_reg.op == OP_LOAD))
        begin
            ld_data_reg <= dmem[x_addr];
        end
    end

    assign result.valid        = w_valid_reg;
    assign result.next_pc      = w_reg.next_pc;
    assign result.branch_taken = w_reg.taken;
    assign result.wb_valid     = w_reg.wb_en;
    assign result.wb_reg       = w_reg.wb_reg;
    assign result.wb_value     = $signed(w_reg.wb_en ? w_value : '0);
    assign result.mem_write    = w_reg.mem_write;
    assign result.mem_addr     = w_reg.mem_addr;
    assign result.mem_data     = $signed(w_reg.mem_data);
    assign result.bad_opcode   = w_reg.bad;

    `CISEU_ASSERT_IMM(a_no_issue_in_clear, !init_done, !q_pop, "item issued during store clear")
    `CISEU_ASSERT_IMM(a_wb_not_r0, w_valid_reg && w_reg.wb_en, w_reg.wb_reg != '0,
                      "write-back to r0")
    `CISEU_ASSERT_IMM(a_bad_is_quiet, w_valid_reg && w_reg.bad,
                      !w_reg.wb_en && !w_reg.mem_write && !w_reg.taken,
                      "bad opcode changed state")
    `CISEU_ASSERT_NEXT(a_pc_follows, adv && x_valid_reg, pc_reg == $past(w_next.next_pc),
                       "pc not updated by executed item")

endmodule

FILE: sv/custom_isa_execute_unit_core.sv
// execute unit top level: front decode, item queue and back end
// depends on ciseu_pkg, ciseu_instr_if, ciseu_result_if, ciseu_front, ciseu_queue, ciseu_back
//
// usage
//   instr  : one 32-bit instruction word per item, in program order
//   result : one item per instruction: next pc, branch flag, write-back,
//            store and bad-opcode flags, in the same order
//   path   : an accepted instruction passes the queue slot, then the execute stage,
//            then the output stage, before its result is valid
//   rate   : one instruction per cycle while result.ready is high; operands are forwarded
//            from the output stage and the last register write, so back-to-back dependent
//            instructions and a load followed by its user do not stall
//   reset  : pc and registers read zero; after reset the data store is swept
//            to zero, one word a cycle, over all DATA_WORDS (1024) words, during
//            which instr.ready stays low
//   stall  : when result.ready is low the output stage holds its item and the
//            execute stage freezes; the two-entry queue keeps taking items
//            until it fills, then instr.ready drops
module custom_isa_execute_unit_core (
    input  logic            clk,
    input  logic            rst_n,
    ciseu_instr_if.sink     instr,
    ciseu_result_if.source  result
);
    import ciseu_pkg::*;

    dec_t   dec;
    dec_t   head_item;
    logic   q_ready;
    logic   head_valid;
    logic   pop;
    logic   init_done;
    logic   push;

    // items are held off until the data store sweep completes
    assign instr.ready = q_ready && init_done;
    assign push        = instr.valid && instr.ready;

    // field split and classification
    ciseu_front u_front (
        .instr_word (instr.instr_word),
        .dec        (dec)
    );

    // decouples accept from execute so each side can stall on its own
    ciseu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (dec),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // register read, execute, data store and output register
    ciseu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (head_valid),
        .q_item     (head_item),
        .q_pop      (pop),
        .init_done  (init_done),
        .result     (result)
    );

endmodule
